// File: hw/rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and helpers of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned SizeW  = 16;
  localparam int unsigned OwnerW = 22;
  localparam int unsigned CountW = 7;
  localparam int unsigned IbcW   = 5;
  localparam int unsigned ListMaxResults = 64;
  localparam logic [16:0] NoFitSize = 17'd99999;
  localparam logic [16:0] FirstBlockKb = 17'd2;
  localparam logic [15:0] TotalReset = 16'd10000;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_LIST  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_OWNER  = 3'd4
  } status_e;

  typedef struct packed {
    logic [SizeW-1:0]  size;
    logic [SizeW-1:0]  origin;
    logic              free;
    logic [OwnerW-1:0] owner;
  } entry_t;

  typedef struct packed {
    status_e           status;
    entry_t            blk;
    logic [CountW-1:0] process_count;
    logic              last;
  } res_t;

  function automatic logic [SizeW-1:0] sat_add(input logic [SizeW-1:0] a,
                                               input logic [SizeW-1:0] b);
    logic [SizeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SizeW] ? {SizeW{1'b1}} : s[SizeW-1:0];
  endfunction

endpackage

// File: hw/rtl/bfa_entry_ram.sv
// ----------------------------------------------------------------------------
// bfa_entry_ram
// Block table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfa_entry_ram import bfa_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned LW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wentry_i,
  input  logic [LW-1:0] wlink_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rentry_o,
  output logic [LW-1:0] rlink_o
);

  entry_t        entries [Depth];
  logic [LW-1:0] links   [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entries[waddr_i] <= wentry_i;
      links[waddr_i]   <= wlink_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rentry_o <= entries[raddr_i];
      rlink_o  <= links[raddr_i];
    end
  end

endmodule

// File: hw/rtl/bfa_out_reg.sv
// ----------------------------------------------------------------------------
// bfa_out_reg
// Result holding register on the output channel.
// ----------------------------------------------------------------------------
module bfa_out_reg import bfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign valid_d = push_i | (valid_q & ~ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a linked block list held in a two-port table RAM.
// ----------------------------------------------------------------------------
// One command is worked on at a time; the next is taken once the sequencer is
// back in idle, even while the last result still waits on the output. The
// block list lives in a RAM with one read and one write per cycle and a
// registered read, which sets the pace: init writes one block per cycle
// (at most 15 blocks); allocate, deallocate and list walk the list with a
// read state and an evaluate state per block; freeing a block adds the
// merge states, and list walks and results wait out any output stall.
// No clearing pass is needed after reset.
module best_fit_block_allocator import bfa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SizeW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [SizeW-1:0]    request_size_i,
  input  logic [OwnerW-1:0]   owner_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [SizeW-1:0]    block_size_o,
  output logic [SizeW-1:0]    block_origin_size_o,
  output logic                block_free_o,
  output logic [OwnerW-1:0]   block_owner_o,
  output logic [CountW-1:0]   process_count_o,
  output logic                last_o
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned IW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SW = IW + 1;
  localparam logic [IW-1:0] Sentinel = IW'(MAX_BLOCKS);
  localparam int unsigned ListMax =
    (MAX_BLOCKS < ListMaxResults) ? MAX_BLOCKS : ListMaxResults;
  localparam logic [SW-1:0] AllocSteps = SW'(MAX_BLOCKS);
  localparam logic [SW-1:0] FreeSteps  = SW'(2 * MAX_BLOCKS);
  localparam logic [SW-1:0] ListSteps  = SW'(ListMax);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_INIT   = 13'b0000000000010,
    S_AL_RD  = 13'b0000000000100,
    S_AL_EV  = 13'b0000000001000,
    S_AL_FIN = 13'b0000000010000,
    S_AL_WR  = 13'b0000000100000,
    S_DA_RD  = 13'b0000001000000,
    S_DA_EV  = 13'b0000010000000,
    S_DA_NX  = 13'b0000100000000,
    S_DA_PRV = 13'b0001000000000,
    S_LS_RD  = 13'b0010000000000,
    S_LS_EV  = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_e;

  state_e                state_q;
  logic [SizeW-1:0]      total_q;
  logic [MAX_BLOCKS-1:0] slot_q;
  logic [IW-1:0]         head_q;
  logic [CountW-1:0]     proc_q;
  logic [IbcW-1:0]       ibc_q;

  logic [SizeW-1:0]      req_q;
  logic [OwnerW-1:0]     owner_q;

  logic [IW-1:0]         cur_q, prev_q, best_q, best_link_q, e_link_q;
  logic [AW-1:0]         new_q;
  logic                  split_q, found_q;
  logic [SW-1:0]         steps_q;
  logic [16:0]           best_size_q, x_q;
  logic [IbcW-1:0]       init_i_q;
  entry_t                best_e_q, e_q, prev_e_q;
  res_t                  res_q;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wentry, rd_e;
  logic [IW-1:0] ram_wlink, rd_link;

  bfa_entry_ram #(.Depth(MAX_BLOCKS), .AW(AW), .LW(IW)) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wentry_i (ram_wentry),
    .wlink_i  (ram_wlink),
    .re_i     (ram_re),
    .raddr_i  (ram_raddr),
    .rentry_o (rd_e),
    .rlink_o  (rd_link)
  );

  // lowest free slot
  logic          free_any;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!slot_q[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic cur_valid, lnk_valid, init_go, init_more, too_large, fits, better;
  logic match, nx_merge, prev_merge, ls_last, out_free, push;
  res_t push_res;
  entry_t merged_prev;

  assign cur_valid  = (cur_q < Sentinel) && slot_q[cur_q[AW-1:0]];
  assign lnk_valid  = (rd_link < Sentinel) && slot_q[rd_link[AW-1:0]];
  assign init_go    = x_q <= {1'b0, total_q};
  assign init_more  = {x_q, 1'b0} <= {2'b00, total_q};
  assign too_large  = {16'd0, req_q} > (32'd1 << ibc_q);
  assign fits       = rd_e.free && (req_q <= rd_e.size);
  assign better     = best_size_q > {1'b0, rd_e.size};
  assign match      = (owner_q != '0) && (rd_e.owner == owner_q);
  assign nx_merge   = (rd_e.origin == e_q.origin) && rd_e.free;
  assign prev_merge = (prev_q != Sentinel) && (prev_e_q.origin == e_q.origin) &&
                      prev_e_q.free;
  assign ls_last    = !lnk_valid || (steps_q + SW'(1) == ListSteps);
  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    merged_prev       = prev_e_q;
    merged_prev.size  = sat_add(prev_e_q.size, e_q.size);
    merged_prev.owner = '0;
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = cur_q[AW-1:0];
    ram_raddr  = cur_q[AW-1:0];
    ram_wentry = e_q;
    ram_wlink  = e_link_q;
    unique case (state_q)
      S_INIT: begin
        if (init_go) begin
          ram_we     = 1'b1;
          ram_waddr  = AW'(init_i_q);
          ram_wentry = '{size: x_q[15:0], origin: x_q[15:0], free: 1'b1, owner: '0};
          ram_wlink  = init_more ? IW'(init_i_q) + IW'(1) : Sentinel;
        end
      end
      S_AL_RD: ram_re = cur_valid && (steps_q < AllocSteps);
      S_DA_RD: ram_re = cur_valid && (steps_q < FreeSteps);
      S_LS_RD: ram_re = cur_valid;
      S_AL_FIN: begin
        if ((best_q != Sentinel) && (best_e_q.size > req_q) && free_any) begin
          ram_we     = 1'b1;
          ram_waddr  = free_idx;
          ram_wentry = '{size: best_e_q.size - req_q, origin: best_e_q.size,
                         free: 1'b1, owner: '0};
          ram_wlink  = best_link_q;
        end
      end
      S_AL_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = best_q[AW-1:0];
        ram_wentry = '{size: req_q, origin: best_e_q.origin, free: 1'b0, owner: owner_q};
        ram_wlink  = split_q ? IW'(new_q) : best_link_q;
      end
      S_DA_EV: begin
        if (match && lnk_valid) begin
          ram_re    = 1'b1;
          ram_raddr = rd_link[AW-1:0];
        end
      end
      S_DA_PRV: begin
        ram_we = 1'b1;
        if (prev_merge) begin
          ram_waddr  = prev_q[AW-1:0];
          ram_wentry = merged_prev;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    push     = 1'b0;
    push_res = res_q;
    push_res.process_count = proc_q;
    if (state_q == S_EMIT) begin
      push = out_free;
    end else if (state_q == S_LS_EV) begin
      push = out_free;
      push_res.status = ST_OK;
      push_res.blk    = rd_e;
      push_res.last   = ls_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q   <= request_size_i;
      owner_q <= owner_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= TotalReset;
      slot_q      <= '0;
      head_q      <= Sentinel;
      proc_q      <= '0;
      ibc_q       <= '0;
      cur_q       <= Sentinel;
      prev_q      <= Sentinel;
      best_q      <= Sentinel;
      best_link_q <= Sentinel;
      e_link_q    <= Sentinel;
      new_q       <= '0;
      split_q     <= 1'b0;
      found_q     <= 1'b0;
      steps_q     <= '0;
      best_size_q <= NoFitSize;
      x_q         <= FirstBlockKb;
      init_i_q    <= '0;
      best_e_q    <= '0;
      e_q         <= '0;
      prev_e_q    <= '0;
      res_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cur_q       <= head_q;
            prev_q      <= Sentinel;
            steps_q     <= '0;
            best_q      <= Sentinel;
            best_size_q <= NoFitSize;
            found_q     <= 1'b0;
            split_q     <= 1'b0;
            res_q       <= '{status: ST_OK, blk: '0, process_count: '0, last: 1'b1};
            unique case (action_e'(action_i))
              ACT_INIT: begin
                slot_q   <= '0;
                head_q   <= Sentinel;
                proc_q   <= '0;
                ibc_q    <= '0;
                x_q      <= FirstBlockKb;
                init_i_q <= '0;
                state_q  <= S_INIT;
              end
              ACT_ALLOC: state_q <= S_AL_RD;
              ACT_FREE:  state_q <= S_DA_RD;
              ACT_LIST:  state_q <= S_LS_RD;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_INIT: begin
          if (init_go) begin
            slot_q[AW'(init_i_q)] <= 1'b1;
            if (init_i_q == '0) begin
              head_q <= '0;
            end
            ibc_q    <= ibc_q + IbcW'(1);
            init_i_q <= init_i_q + IbcW'(1);
            x_q      <= {x_q[15:0], 1'b0};
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_AL_RD: begin
          if (too_large) begin
            res_q.status <= ST_TOO_LARGE;
            state_q      <= S_EMIT;
          end else if (cur_valid && (steps_q < AllocSteps)) begin
            state_q <= S_AL_EV;
          end else begin
            state_q <= S_AL_FIN;
          end
        end
        S_AL_EV: begin
          if (fits && better) begin
            best_q      <= cur_q;
            best_e_q    <= rd_e;
            best_link_q <= rd_link;
            best_size_q <= {1'b0, rd_e.size};
          end
          cur_q   <= rd_link;
          steps_q <= steps_q + SW'(1);
          state_q <= S_AL_RD;
        end
        S_AL_FIN: begin
          if (best_q == Sentinel) begin
            res_q.status <= ST_NO_FIT;
            state_q      <= S_EMIT;
          end else if (best_e_q.size > req_q) begin
            if (free_any) begin
              slot_q[free_idx] <= 1'b1;
              new_q            <= free_idx;
              split_q          <= 1'b1;
              state_q          <= S_AL_WR;
            end else begin
              res_q.status <= ST_FULL;
              state_q      <= S_EMIT;
            end
          end else begin
            state_q <= S_AL_WR;
          end
        end
        S_AL_WR: begin
          if (proc_q != {CountW{1'b1}}) begin
            proc_q <= proc_q + CountW'(1);
          end
          res_q.blk <= '{size: req_q, origin: best_e_q.origin, free: 1'b0,
                         owner: owner_q};
          state_q   <= S_EMIT;
        end
        S_DA_RD: begin
          if (cur_valid && (steps_q < FreeSteps)) begin
            state_q <= S_DA_EV;
          end else begin
            res_q.status <= found_q ? ST_OK : ST_NO_OWNER;
            state_q      <= S_EMIT;
          end
        end
        S_DA_EV: begin
          if (match) begin
            found_q  <= 1'b1;
            e_q      <= '{size: rd_e.size, origin: rd_e.origin, free: 1'b1, owner: '0};
            e_link_q <= rd_link;
            if (proc_q != '0) begin
              proc_q <= proc_q - CountW'(1);
            end
            state_q <= lnk_valid ? S_DA_NX : S_DA_PRV;
          end else begin
            prev_q      <= cur_q;
            prev_e_q    <= rd_e;
            cur_q       <= rd_link;
            steps_q     <= steps_q + SW'(1);
            state_q     <= S_DA_RD;
          end
        end
        S_DA_NX: begin
          // absorb the free next neighbor of the same origin
          if (nx_merge) begin
            e_q.size                  <= sat_add(e_q.size, rd_e.size);
            e_link_q                  <= rd_link;
            slot_q[e_link_q[AW-1:0]]  <= 1'b0;
          end
          state_q <= S_DA_PRV;
        end
        S_DA_PRV: begin
          if (prev_merge) begin
            // fold into the previous block; it stays the walk's previous
            prev_e_q              <= merged_prev;
            slot_q[cur_q[AW-1:0]] <= 1'b0;
          end else begin
            prev_q      <= cur_q;
            prev_e_q    <= e_q;
          end
          cur_q   <= e_link_q;
          steps_q <= steps_q + SW'(1);
          state_q <= S_DA_RD;
        end
        S_LS_RD: begin
          if (cur_valid) begin
            state_q <= S_LS_EV;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_LS_EV: begin
          if (out_free) begin
            if (ls_last) begin
              state_q <= S_IDLE;
            end else begin
              cur_q   <= rd_link;
              steps_q <= steps_q + SW'(1);
              state_q <= S_LS_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  res_t out_res;

  bfa_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (push_res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign status_o            = out_res.status;
  assign block_size_o        = out_res.blk.size;
  assign block_origin_size_o = out_res.blk.origin;
  assign block_free_o        = out_res.blk.free;
  assign block_owner_o       = out_res.blk.owner;
  assign process_count_o     = out_res.process_count;
  assign last_o              = out_res.last;

`ifndef SYNTH
  // the list head is never merged away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != Sentinel) |-> slot_q[head_q[AW-1:0]])
    else $error("list head points at an unused slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("table read and write hit the same entry in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while a command is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed over an untaken result");
`endif

endmodule

// File: verif/best_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_tb
// Self-checking bench: directed command table, then random alloc/free/list/init
// traffic, every result compared against an in-bench model of the block list.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_tb;
  import bfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NB = 64;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct {
    action_e           act;
    logic [SizeW-1:0]  req;
    logic [OwnerW-1:0] owner;
    bit                has_exp;
    status_e           exp_status;
  } cmd_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [SizeW-1:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [1:0] action;
  logic [SizeW-1:0] req_size;
  logic [OwnerW-1:0] owner_id;
  logic out_valid, out_ready;
  logic [2:0] status;
  logic [SizeW-1:0] blk_size, blk_origin;
  logic blk_free;
  logic [OwnerW-1:0] blk_owner;
  logic [CountW-1:0] proc_count;
  logic last;

  best_fit_block_allocator i_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .action_i(action),
    .request_size_i(req_size), .owner_id_i(owner_id),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .status_o(status),
    .block_size_o(blk_size), .block_origin_size_o(blk_origin),
    .block_free_o(blk_free), .block_owner_o(blk_owner),
    .process_count_o(proc_count), .last_o(last)
  );

  // allocator model state
  logic [SizeW-1:0]  m_size[NB];
  logic [SizeW-1:0]  m_origin[NB];
  bit                m_free[NB];
  logic [OwnerW-1:0] m_owner[NB];
  int unsigned       m_link[NB];
  bit                m_used[NB];
  int unsigned       m_head, m_procs, m_nblocks;
  logic [SizeW-1:0]  m_total;

  res_t expected_q[$];
  int   errors, n_items, n_results, n_full, n_merge_lists, stall_cycles;
  bit   hold_off;

  function automatic bit live(int unsigned i);
    return i < NB && m_used[i];
  endfunction

  function automatic int unsigned free_slot();
    for (int unsigned i = 0; i < NB; i++) if (!m_used[i]) return i;
    return NB;
  endfunction

  function automatic logic [SizeW-1:0] add_sat(logic [SizeW-1:0] a, logic [SizeW-1:0] b);
    int unsigned s;
    s = a + b;
    return s > 16'hFFFF ? 16'hFFFF : s[SizeW-1:0];
  endfunction

  function automatic res_t make_res(status_e st, int unsigned idx, bit lst);
    res_t r;
    r.status = st;
    if (idx < NB) begin
      r.blk.size = m_size[idx];
      r.blk.origin = m_origin[idx];
      r.blk.free = m_free[idx];
      r.blk.owner = m_owner[idx];
    end else begin
      r.blk = '0;
    end
    r.process_count = m_procs[CountW-1:0];
    r.last = lst;
    return r;
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < NB; i++) begin
      m_used[i] = 0; m_size[i] = 0; m_origin[i] = 0;
      m_free[i] = 0; m_owner[i] = 0; m_link[i] = 0;
    end
    m_head = NB; m_procs = 0; m_nblocks = 0;
  endfunction

  function automatic status_e alloc_block(int unsigned rq, int unsigned ow,
                                          output int unsigned fit);
    int unsigned cur, best, best_sz, s;
    cur = m_head; best = NB; best_sz = 99999; fit = NB;
    if (64'(rq) > (64'd1 << (m_nblocks & 31))) return ST_TOO_LARGE;
    for (int st = 0; st < NB && live(cur); st++) begin
      if (m_free[cur] && rq <= m_size[cur] && best_sz > m_size[cur]) begin
        best = cur; best_sz = m_size[cur];
      end
      cur = m_link[cur];
    end
    if (best >= NB) return ST_NO_FIT;
    if (m_size[best] > rq) begin
      s = free_slot();
      if (s >= NB) return ST_FULL;
      m_used[s] = 1;
      m_size[s] = SizeW'(m_size[best] - rq);
      m_origin[s] = m_size[best];
      m_free[s] = 1; m_owner[s] = 0;
      m_link[s] = m_link[best];
      m_link[best] = s;
    end
    m_size[best] = SizeW'(rq); m_free[best] = 0; m_owner[best] = OwnerW'(ow);
    if (m_procs < 127) m_procs++;
    fit = best;
    return ST_OK;
  endfunction

  function automatic status_e free_owner(int unsigned ow);
    int unsigned cur, prv, nx;
    bit found;
    cur = m_head; prv = NB; found = 0;
    for (int st = 0; st < 2*NB && live(cur); st++) begin
      if (ow != 0 && m_owner[cur] == ow) begin
        found = 1; m_free[cur] = 1; m_owner[cur] = 0;
        if (m_procs > 0) m_procs--;
        nx = m_link[cur];
        if (live(nx) && m_origin[nx] == m_origin[cur] && m_free[nx]) begin
          m_size[cur] = add_sat(m_size[cur], m_size[nx]);
          m_link[cur] = m_link[nx]; m_used[nx] = 0;
        end
        if (live(prv) && m_origin[prv] == m_origin[cur] && m_free[prv]) begin
          m_size[prv] = add_sat(m_size[prv], m_size[cur]);
          m_link[prv] = m_link[cur]; m_used[cur] = 0;
          cur = prv; m_owner[cur] = 0;
        end
      end
      prv = cur;
      cur = m_link[cur];
    end
    return found ? ST_OK : ST_NO_OWNER;
  endfunction

  // Predict results of one command and queue them; returns first status.
  function automatic status_e predict_cmd(action_e act, int unsigned rq, int unsigned ow);
    int unsigned fit, cur, n, x, s, tail;
    status_e st;
    case (act)
      ACT_INIT: begin
        reset_table();
        x = 2; tail = NB;
        while (x <= m_total) begin
          s = free_slot();
          if (s >= NB) break;
          m_used[s] = 1; m_size[s] = SizeW'(x); m_origin[s] = SizeW'(x);
          m_free[s] = 1; m_owner[s] = 0; m_link[s] = NB;
          if (tail >= NB) m_head = s; else m_link[tail] = s;
          tail = s;
          m_nblocks = (m_nblocks + 1) & 31;
          x *= 2;
        end
        expected_q.push_back(make_res(ST_OK, NB, 1));
        return ST_OK;
      end
      ACT_ALLOC: begin
        st = alloc_block(rq, ow, fit);
        if (st == ST_FULL) n_full++;
        expected_q.push_back(make_res(st, st == ST_OK ? fit : NB, 1));
        return st;
      end
      ACT_FREE: begin
        st = free_owner(ow);
        expected_q.push_back(make_res(st, NB, 1));
        return st;
      end
      default: begin
        cur = m_head; n = 0;
        for (int k = 0; k < NB && live(cur); k++) begin
          expected_q.push_back(make_res(ST_OK, cur, 0));
          n++;
          cur = m_link[cur];
        end
        if (n == 0) expected_q.push_back(make_res(ST_OK, NB, 1));
        else expected_q[$].last = 1;
        n_merge_lists++;
        return ST_OK;
      end
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status=%0d", status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (blk_size !== e.blk.size) begin
          $error("block_size exp %0d got %0d", e.blk.size, blk_size); errors++;
        end
        if (blk_origin !== e.blk.origin) begin
          $error("block_origin_size exp %0d got %0d", e.blk.origin, blk_origin); errors++;
        end
        if (blk_free !== e.blk.free) begin
          $error("block_free exp %0d got %0d", e.blk.free, blk_free); errors++;
        end
        if (blk_owner !== e.blk.owner) begin
          $error("block_owner exp %0d got %0d", e.blk.owner, blk_owner); errors++;
        end
        if (proc_count !== e.process_count) begin
          $error("process_count exp %0d got %0d", e.process_count, proc_count); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int w;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        for (int k = 0; k < 400; k++) @(negedge clk);
        hold_off = 0;
      end
      w = stall_cycles ? $urandom_range(0, 19) : 0;
      if (w > 0) begin
        out_ready <= 0;
        repeat (w - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
        do @(posedge clk); while (!(out_valid && out_ready));
      end
    end
  end

  // watchdog on accepted transactions
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= WatchdogLimit) begin
        $display("[best_fit_block_allocator] ERROR");
        $finish;
      end
    end
  end

  // valid is dropped only for a gap or by drain, so it gets one update per edge
  task automatic send_cmd(action_e act, int unsigned rq, int unsigned ow, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 19) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1;
    action <= act;
    req_size <= rq[SizeW-1:0];
    owner_id <= ow[OwnerW-1:0];
    do @(posedge clk); while (!in_ready);
    void'(predict_cmd(act, rq, ow));
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain(int extra);
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_total(logic [SizeW-1:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    m_total = v;
  endtask

  // random phase: allocate-heavy traffic with frees, lists and occasional inits
  task automatic random_phase(int count, bit gaps);
    int unsigned r, ow, rq;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      ow = ($urandom_range(0, 9) == 0) ? $urandom() & 22'h3FFFFF : $urandom_range(0, 7);
      if ($urandom_range(0, 5) == 0) rq = $urandom() & 16'hFFFF;
      else rq = $urandom_range(0, 1 << $urandom_range(1, 14));
      if (r < 50) send_cmd(ACT_ALLOC, rq, ow, gaps);
      else if (r < 75) send_cmd(ACT_FREE, rq, ow, gaps);
      else if (r < 95) send_cmd(ACT_LIST, rq, ow, gaps);
      else send_cmd(ACT_INIT, rq, ow, gaps);
    end
  endtask

  cmd_t directed[$];

  initial begin
    status_e got;
    errors = 0; n_items = 0; n_results = 0; n_full = 0; n_merge_lists = 0;
    stall_cycles = 1; hold_off = 0;
    rst_n = 0; cfg_we = 0; cfg_wdata = '0; in_valid = 0;
    action = '0; req_size = '0; owner_id = '0;
    m_total = TotalReset;
    reset_table();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // list on empty table, then default-size init and extremes
    directed = '{
      '{ACT_LIST,  16'd0,     22'd0,        1, ST_OK},
      '{ACT_ALLOC, 16'd1,     22'd5,        1, ST_NO_FIT},
      '{ACT_FREE,  16'd0,     22'd5,        1, ST_NO_OWNER},
      '{ACT_INIT,  16'hFFFF,  22'h3FFFFF,   1, ST_OK},
      '{ACT_LIST,  16'd0,     22'd0,        0, ST_OK},
      '{ACT_ALLOC, 16'hFFFF,  22'd1,        1, ST_TOO_LARGE},
      '{ACT_ALLOC, 16'd8,     22'd1,        1, ST_OK},
      '{ACT_ALLOC, 16'd0,     22'd2,        1, ST_OK},
      '{ACT_ALLOC, 16'd3,     22'h3FFFFF,   1, ST_OK},
      '{ACT_ALLOC, 16'd5,     22'd0,        1, ST_OK},
      '{ACT_ALLOC, 16'd8192,  22'd3,        0, ST_OK},
      '{ACT_ALLOC, 16'd8192,  22'd3,        1, ST_NO_FIT},
      '{ACT_LIST,  16'd0,     22'd0,        0, ST_OK},
      '{ACT_FREE,  16'd0,     22'd0,        1, ST_NO_OWNER},
      '{ACT_FREE,  16'd0,     22'h3FFFFF,   1, ST_OK},
      '{ACT_FREE,  16'd0,     22'd1,        1, ST_OK},
      '{ACT_FREE,  16'd0,     22'd2,        1, ST_OK},
      '{ACT_LIST,  16'd0,     22'd0,        0, ST_OK},
      '{ACT_ALLOC, 16'd2,     22'd9,        0, ST_OK},
      '{ACT_INIT,  16'd0,     22'd0,        1, ST_OK},
      '{ACT_LIST,  16'd0,     22'd0,        0, ST_OK}
    };
    foreach (directed[i]) begin
      send_cmd(directed[i].act, directed[i].req, directed[i].owner, i[0]);
      got = expected_q.size() ? expected_q[$].status : ST_OK;
      if (directed[i].has_exp && got !== directed[i].exp_status) begin
        $error("directed row %0d: table status %0d, model %0d",
               i, directed[i].exp_status, got);
        errors++;
      end
    end
    drain(20);

    // tiny total: init lays out nothing
    write_total(16'd1);
    send_cmd(ACT_INIT, 0, 0, 0);
    send_cmd(ACT_LIST, 0, 0, 0);
    send_cmd(ACT_ALLOC, 0, 4, 0);
    drain(20);

    // largest total, random traffic; long output hold-off while input streams
    write_total(16'hFFFF);
    send_cmd(ACT_INIT, 0, 0, 0);
    hold_off = 1;
    for (int i = 0; i < 6; i++) send_cmd(ACT_ALLOC, $urandom_range(0, 40), i + 1, 0);
    random_phase(10, 1);
    drain(300);

    // small total: table fills with tiny splits, hits table-full
    write_total(16'd2);
    send_cmd(ACT_INIT, 0, 0, 0);
    for (int i = 0; i < 66; i++) send_cmd(ACT_ALLOC, 0, (i % 3) + 1, 0);
    send_cmd(ACT_LIST, 0, 0, 0);
    send_cmd(ACT_FREE, 0, 2, 0);
    send_cmd(ACT_LIST, 0, 0, 0);
    drain(300);

    // random total, no stalls then stalls
    write_total(SizeW'($urandom_range(2, 65535)));
    send_cmd(ACT_INIT, 0, 0, 0);
    stall_cycles = 0;
    random_phase(5, 0);
    stall_cycles = 1;
    random_phase(15, 1);
    drain(300);

    $display("Ran %0d commands, %0d results checked, %0d list walks, %0d table-full cases.",
             n_items, n_results, n_merge_lists, n_full);
    if (errors == 0) begin
      $display("[best_fit_block_allocator] OK");
    end else begin
      $display("[best_fit_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_entry_ram.sv
hw/rtl/bfa_out_reg.sv
hw/rtl/best_fit_block_allocator.sv
verif/best_fit_block_allocator_tb.sv
